[sv/cirq_pkg.sv]
// shared types and codes for the cartridge irq counter and tone unit
`default_nettype none

package cirq_pkg;

    localparam int TONE_SLOTS    = 3;
    localparam int TONE_CHANNELS = 3;

    localparam logic [1:0] REQ_BUS_WRITE  = 2'd0;
    localparam logic [1:0] REQ_CPU_TICK   = 2'd1;
    localparam logic [1:0] REQ_AUDIO_TICK = 2'd2;

    localparam logic [2:0] REGION_CMD_SELECT   = 3'b100;
    localparam logic [2:0] REGION_CMD_DATA     = 3'b101;
    localparam logic [2:0] REGION_SOUND_SELECT = 3'b110;
    localparam logic [2:0] REGION_SOUND_DATA   = 3'b111;

    localparam logic [3:0] CMD_IRQ_CONTROL = 4'hD;
    localparam logic [3:0] CMD_COUNT_LOW   = 4'hE;
    localparam logic [3:0] CMD_COUNT_HIGH  = 4'hF;

    localparam logic [3:0] SND_PERIOD_BASE = 4'h0;
    localparam logic [3:0] SND_DISABLE     = 4'h7;
    localparam logic [3:0] SND_VOLUME_BASE = 4'h8;

    localparam int TRIGGER_BIT = 0;
    localparam int COUNT_BIT   = 7;
    localparam int PHASE_MSB   = 4;

    typedef struct packed {
        logic       period_lo_we;
        logic       period_hi_we;
        logic       off_we;
        logic       off_val;
        logic       volume_we;
        logic [7:0] data;
    } tone_wr_t;

endpackage

`default_nettype wire

[sv/cartridge_irq_counter_tone_unit.sv]
// top level: input register, write decode, counter and tones, result register
//
// Each word is a bus write, a cpu cycle tick or an audio tick. A word is held in
// the input register, the counter and the three tone channels update from it as
// it leaves, and the irq level and held tone levels after the word are loaded
// into the result register. One word is taken every cycle unless the result
// register stalls, and its result is offered by the result register; a stalled
// result register holds the input register, and req_stall follows from that.
`default_nettype none

module cartridge_irq_counter_tone_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [15:0] bus_address,
    input  wire logic [7:0]  bus_data,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic             irq_line,
    output logic [3:0]       tone_a_level,
    output logic [3:0]       tone_b_level,
    output logic [3:0]       tone_c_level
);
    import cirq_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  kind_reg;
    logic [2:0]  region_reg;
    logic [7:0]  data_reg;
    logic        out_valid_reg;
    logic        irq_reg;
    logic [3:0]  level_reg [TONE_SLOTS];
    logic [3:0]  sound_index_reg, sound_index_next;

    logic        rsp_free;
    logic        exec;
    logic        accept;
    logic        sound_write;
    logic        audio_step;
    logic        irq_next;
    logic [3:0]  level_next [TONE_SLOTS];

    assign rsp_free  = !out_valid_reg || !rsp_stall;
    assign exec      = in_valid_reg && rsp_free;
    assign req_stall = in_valid_reg && !rsp_free;
    assign accept    = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (exec)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= req_type;
            region_reg <= bus_address[15:13];
            data_reg   <= bus_data;
        end
    end

    // sound register select
    always_comb
    begin
        sound_index_next = sound_index_reg;
        if (exec && kind_reg == REQ_BUS_WRITE && region_reg == REGION_SOUND_SELECT)
        begin
            sound_index_next = data_reg[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_index_reg <= '0;
        end
        else
        begin
            sound_index_reg <= sound_index_next;
        end
    end

    assign sound_write = exec && kind_reg == REQ_BUS_WRITE && region_reg == REGION_SOUND_DATA;
    assign audio_step  = exec && kind_reg == REQ_AUDIO_TICK;

    cirq_counter u_counter (
        .clk      (clk),
        .rst_n    (rst_n),
        .exec     (exec),
        .kind     (kind_reg),
        .region   (region_reg),
        .data     (data_reg),
        .irq_next (irq_next)
    );

    for (genvar t = 0; t < TONE_SLOTS; t++)
    begin : g_tone
        if (t < TONE_CHANNELS)
        begin : g_present
            tone_wr_t wr;

            assign wr.period_lo_we = sound_write
                && sound_index_reg == SND_PERIOD_BASE + 4'(2 * t);
            assign wr.period_hi_we = sound_write
                && sound_index_reg == SND_PERIOD_BASE + 4'(2 * t + 1);
            assign wr.off_we       = sound_write && sound_index_reg == SND_DISABLE;
            assign wr.off_val      = data_reg[t];
            assign wr.volume_we    = sound_write
                && sound_index_reg == SND_VOLUME_BASE + 4'(t);
            assign wr.data         = data_reg;

            cirq_tone u_tone (
                .clk        (clk),
                .rst_n      (rst_n),
                .step       (audio_step),
                .wr         (wr),
                .level_next (level_next[t])
            );
        end
        else
        begin : g_absent
            assign level_next[t] = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            irq_reg <= irq_next;
            for (int i = 0; i < TONE_SLOTS; i++)
            begin
                level_reg[i] <= level_next[i];
            end
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign irq_line     = irq_reg;
    assign tone_a_level = level_reg[0];
    assign tone_b_level = level_reg[1];
    assign tone_c_level = level_reg[2];

    // input side only stalls when both stages hold a word
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> in_valid_reg && out_valid_reg && rsp_stall)
        else $error("input stalled with room in the pipe");

endmodule

`default_nettype wire

[sv/cirq_counter.sv]
// command register decode and 16-bit irq down counter
`default_nettype none

module cirq_counter (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       exec,
    input  wire logic [1:0] kind,
    input  wire logic [2:0] region,
    input  wire logic [7:0] data,
    output logic            irq_next
);
    import cirq_pkg::*;

    logic [3:0]  cmd_index_reg, cmd_index_next;
    logic [15:0] counter_reg, counter_next;
    logic        count_enable_reg, count_enable_next;
    logic        trigger_enable_reg, trigger_enable_next;
    logic        irq_flag_reg, irq_flag_next;
    logic [15:0] counter_dec;

    assign counter_dec = counter_reg - 16'd1;

    always_comb
    begin
        cmd_index_next      = cmd_index_reg;
        counter_next        = counter_reg;
        count_enable_next   = count_enable_reg;
        trigger_enable_next = trigger_enable_reg;
        irq_flag_next       = irq_flag_reg;
        if (exec && kind == REQ_BUS_WRITE)
        begin
            if (region == REGION_CMD_SELECT)
            begin
                cmd_index_next = data[3:0];
            end
            else if (region == REGION_CMD_DATA)
            begin
                unique case (cmd_index_reg)
                    CMD_IRQ_CONTROL:
                    begin
                        trigger_enable_next = data[TRIGGER_BIT];
                        count_enable_next   = data[COUNT_BIT];
                        if (!data[TRIGGER_BIT])
                        begin
                            irq_flag_next = 1'b0;
                        end
                    end
                    CMD_COUNT_LOW:  counter_next = {counter_reg[15:8], data};
                    CMD_COUNT_HIGH: counter_next = {data, counter_reg[7:0]};
                    default: ;
                endcase
            end
        end
        else if (exec && kind == REQ_CPU_TICK && count_enable_reg)
        begin
            counter_next = counter_dec;
            if (counter_dec == 16'd0 && trigger_enable_reg)
            begin
                irq_flag_next = 1'b1;
            end
        end
    end

    assign irq_next = irq_flag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_index_reg      <= '0;
            counter_reg        <= '0;
            count_enable_reg   <= 1'b0;
            trigger_enable_reg <= 1'b0;
            irq_flag_reg       <= 1'b0;
        end
        else
        begin
            cmd_index_reg      <= cmd_index_next;
            counter_reg        <= counter_next;
            count_enable_reg   <= count_enable_next;
            trigger_enable_reg <= trigger_enable_next;
            irq_flag_reg       <= irq_flag_next;
        end
    end

    // flag can only stand while the trigger is enabled
    a_flag_needs_trigger: assert property (@(posedge clk) disable iff (!rst_n)
        irq_flag_reg |-> trigger_enable_reg)
        else $error("irq flag set without trigger enable");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        exec && kind == REQ_CPU_TICK && !count_enable_reg |=> $stable(counter_reg))
        else $error("counter moved while disabled");

endmodule

`default_nettype wire

[sv/cirq_tone.sv]
// one square tone: period, disable, volume, timer, phase and held level
`default_nettype none

module cirq_tone (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire cirq_pkg::tone_wr_t wr,
    output logic [3:0]             level_next
);
    import cirq_pkg::*;

    logic [11:0] period_reg, period_next;
    logic [12:0] timer_reg, timer_next;
    logic [4:0]  phase_reg, phase_next;
    logic        off_reg, off_next;
    logic [3:0]  volume_reg, volume_next;
    logic [3:0]  level_reg;
    logic [12:0] timer_dec;

    assign timer_dec = timer_reg - 13'd1;

    always_comb
    begin
        period_next = period_reg;
        off_next    = off_reg;
        volume_next = volume_reg;
        timer_next  = timer_reg;
        phase_next  = phase_reg;
        level_next  = level_reg;
        if (wr.period_lo_we)
        begin
            period_next = {period_reg[11:8], wr.data};
        end
        if (wr.period_hi_we)
        begin
            period_next = {wr.data[3:0], period_reg[7:0]};
        end
        if (wr.off_we)
        begin
            off_next = wr.off_val;
        end
        if (wr.volume_we)
        begin
            volume_next = wr.data[3:0];
        end
        if (step)
        begin
            if (timer_dec == 13'd0)
            begin
                phase_next = phase_reg + 5'd1;
                timer_next = {1'b0, period_reg} + 13'd1;
            end
            else
            begin
                timer_next = timer_dec;
            end
            level_next = (!off_reg && phase_next[PHASE_MSB]) ? volume_reg : 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            timer_reg  <= 13'd1;
            phase_reg  <= '0;
            off_reg    <= 1'b0;
            volume_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            period_reg <= period_next;
            timer_reg  <= timer_next;
            phase_reg  <= phase_next;
            off_reg    <= off_next;
            volume_reg <= volume_next;
            level_reg  <= level_next;
        end
    end

    // a step either reloads or leaves a nonzero count
    a_timer_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> timer_reg != 13'd0)
        else $error("tone timer left at zero");

    a_level_held: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(level_reg))
        else $error("tone level changed without an audio tick");

endmodule

`default_nettype wire
